FILE: rtl/core/ascon_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ascon_pkg
// Shared types, round constants and the round function of the 320-bit
// Ascon-p permutation.
// ----------------------------------------------------------------------------
package ascon_pkg;

    localparam int unsigned WORD_W     = 64;
    localparam int unsigned NUM_WORDS  = 5;
    localparam int unsigned MAX_ROUNDS = 16;
    localparam int unsigned RCNT_W     = 5;
    localparam int unsigned RIDX_W     = 4;

    typedef logic [NUM_WORDS-1:0][WORD_W-1:0] state_t;

    // Round constants, indexed by 16 - rounds + round number
    localparam logic [7:0] RC_TABLE [MAX_ROUNDS] = '{
        8'h3c, 8'h2d, 8'h1e, 8'h0f, 8'hf0, 8'he1, 8'hd2, 8'hc3,
        8'hb4, 8'ha5, 8'h96, 8'h87, 8'h78, 8'h69, 8'h5a, 8'h4b
    };

    // Controller to datapath commands
    typedef struct packed {
        logic              load;      // capture a new input state
        logic              round;     // apply one round to the working state
        logic [RIDX_W-1:0] rc_idx;    // constant table entry for this round
        logic              out_load;  // move working state to output register
    } ascon_cmd_t;

    function automatic logic [WORD_W-1:0] rotr(input logic [WORD_W-1:0] v,
                                               input int unsigned amt);
        return (v >> amt) | (v << (WORD_W - amt));
    endfunction

    // One full round: constant addition, S-box layer, linear layer
    function automatic state_t ascon_round(input state_t s, input logic [7:0] rc);
        logic [WORD_W-1:0] a, b, c, d, e;
        logic [WORD_W-1:0] n0, n1, n2, n3, n4;
        state_t r;
        a = s[0];
        b = s[1];
        c = s[2] ^ {{(WORD_W-8){1'b0}}, rc};
        d = s[3];
        e = s[4];
        a = a ^ e;
        e = e ^ d;
        c = c ^ b;
        n0 = ~a & b;
        n1 = ~b & c;
        n2 = ~c & d;
        n3 = ~d & e;
        n4 = ~e & a;
        a = a ^ n1;
        b = b ^ n2;
        c = c ^ n3;
        d = d ^ n4;
        e = e ^ n0;
        b = b ^ a;
        a = a ^ e;
        d = d ^ c;
        c = ~c;
        r[0] = a ^ rotr(a, 19) ^ rotr(a, 28);
        r[1] = b ^ rotr(b, 61) ^ rotr(b, 39);
        r[2] = c ^ rotr(c, 1)  ^ rotr(c, 6);
        r[3] = d ^ rotr(d, 10) ^ rotr(d, 17);
        r[4] = e ^ rotr(e, 7)  ^ rotr(e, 41);
        return r;
    endfunction

endpackage

FILE: rtl/core/ascon_permutation_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ascon_permutation_unit
// Ascon-p permutation on a 320-bit state, one round per clock.
// ----------------------------------------------------------------------------
// An item is loaded, runs N rounds (N = rounds, 0..16), then moves to the output
// register; a single round unit is iterated, so a new item waits until it leaves.
// A new item is taken while the previous result still waits in the output.
// A finished state holds in the round register until the output is free.
// Reset (synchronous, active low) clears the controller and output valid;
// the state registers are not reset.
// ----------------------------------------------------------------------------
module ascon_permutation_unit
    import ascon_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [WORD_W-1:0] s_word_in_0,
    input  logic [WORD_W-1:0] s_word_in_1,
    input  logic [WORD_W-1:0] s_word_in_2,
    input  logic [WORD_W-1:0] s_word_in_3,
    input  logic [WORD_W-1:0] s_word_in_4,
    input  logic [RCNT_W-1:0] s_round_count,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [WORD_W-1:0] m_word_out_0,
    output logic [WORD_W-1:0] m_word_out_1,
    output logic [WORD_W-1:0] m_word_out_2,
    output logic [WORD_W-1:0] m_word_out_3,
    output logic [WORD_W-1:0] m_word_out_4
);

    ascon_cmd_t cmd;
    state_t     state_in;
    state_t     state_out;

    assign state_in = {s_word_in_4, s_word_in_3, s_word_in_2, s_word_in_1, s_word_in_0};

    ascon_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_round_count (s_round_count),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .cmd           (cmd)
    );

    ascon_datapath u_datapath (
        .aclk      (aclk),
        .cmd       (cmd),
        .state_in  (state_in),
        .state_out (state_out)
    );

    assign m_word_out_0 = state_out[0];
    assign m_word_out_1 = state_out[1];
    assign m_word_out_2 = state_out[2];
    assign m_word_out_3 = state_out[3];
    assign m_word_out_4 = state_out[4];

    // Load, round and output load never overlap
    assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.load, cmd.round, cmd.out_load}))
        else $error("datapath commands overlap");

    // No input transfer while rounds are in progress
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.round |-> !s_ready)
        else $error("input ready during rounds");

    // A nonzero round count starts the round sequence next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_round_count != '0)) |=> cmd.round)
        else $error("rounds did not start");

    // An output load always presents a result
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> m_valid)
        else $error("result not presented after output load");

endmodule

FILE: rtl/core/ascon_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ascon_ctrl
// Round sequencer: accepts an item, steps the round counter, hands the
// finished state to the output register and tracks its valid flag.
// ----------------------------------------------------------------------------
module ascon_ctrl
    import ascon_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [RCNT_W-1:0] s_round_count,
    output logic              m_valid,
    input  logic              m_ready,
    output ascon_cmd_t        cmd
);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_RUN   = 3'b010,
        ST_DRAIN = 3'b100
    } ctrl_state_t;

    ctrl_state_t       state_reg, state_next;
    logic [RIDX_W-1:0] rc_idx_reg, rc_idx_next;
    logic              m_valid_reg, m_valid_next;
    logic [RCNT_W-1:0] rounds_sat;
    logic [RCNT_W-1:0] start_idx;
    logic              in_xfer;
    logic              out_load;

    // Saturate the round count and find the first table entry
    assign rounds_sat = (s_round_count > RCNT_W'(MAX_ROUNDS)) ? RCNT_W'(MAX_ROUNDS)
                                                               : s_round_count;
    assign start_idx  = RCNT_W'(MAX_ROUNDS) - rounds_sat;

    // Hold off input transfers while reset is asserted
    assign s_ready  = (state_reg == ST_IDLE) && aresetn;
    assign in_xfer  = s_valid && s_ready;
    assign out_load = (state_reg == ST_DRAIN) && (!m_valid_reg || m_ready);
    assign m_valid  = m_valid_reg;

    // Next-state logic
    always_comb begin
        state_next  = state_reg;
        rc_idx_next = rc_idx_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    rc_idx_next = start_idx[RIDX_W-1:0];
                    state_next  = (rounds_sat == '0) ? ST_DRAIN : ST_RUN;
                end
            end
            ST_RUN: begin
                rc_idx_next = rc_idx_reg + 1'b1;
                if (rc_idx_reg == RIDX_W'(MAX_ROUNDS - 1)) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output valid: set on load, drop on transfer
    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            rc_idx_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            rc_idx_reg  <= rc_idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Drive datapath commands
    always_comb begin
        cmd.load     = in_xfer;
        cmd.round    = (state_reg == ST_RUN);
        cmd.rc_idx   = rc_idx_reg;
        cmd.out_load = out_load;
    end

endmodule

FILE: rtl/core/ascon_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ascon_datapath
// Working state register with one round of logic, and the output register.
// ----------------------------------------------------------------------------
module ascon_datapath
    import ascon_pkg::*;
(
    input  logic       aclk,
    input  ascon_cmd_t cmd,
    input  state_t     state_in,
    output state_t     state_out
);

    state_t work_reg, work_next;
    state_t out_reg;

    // Load or advance the working state
    always_comb begin
        work_next = work_reg;
        if (cmd.load) begin
            work_next = state_in;
        end else if (cmd.round) begin
            work_next = ascon_round(work_reg, RC_TABLE[cmd.rc_idx]);
        end
    end

    always_ff @(posedge aclk) begin
        work_reg <= work_next;
        if (cmd.out_load) begin
            out_reg <= work_reg;
        end
    end

    assign state_out = out_reg;

endmodule
